// File: design/lms_predictor_normalized_defines.svh
// assertion macros used by the checker file
`ifndef LMS_PREDICTOR_NORMALIZED_DEFINES_SVH
`define LMS_PREDICTOR_NORMALIZED_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LMSP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lmsp assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define LMSP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lmsp assertion failed");

`endif

// File: design/lmsp_pkg.sv
// ----------------------------------------------------------------------------
// lmsp_pkg
// Types, widths, constants and saturation helpers for the LMS predictor.
// ----------------------------------------------------------------------------
package lmsp_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int W_W        = 24;
    localparam int M_W        = 17;
    localparam int PROD_W     = 41;
    localparam int ACC_W      = 43;
    localparam int ERR_W      = 25;
    localparam int EM_W       = 42;
    localparam int LR_W       = 17;
    localparam int LR_FRAC    = 16;
    localparam int FULL_W     = 60;
    localparam int NUM_W      = 60;
    localparam int DEN_W      = 32;
    localparam int DCNT_W     = 6;
    localparam int SQ_W       = 48;
    localparam int SSUM_W     = 50;
    localparam int ROOT_W     = 26;
    localparam int SUM_W      = 31;
    localparam int LANES      = 4;

    // divide by 25 through a reciprocal, after a power-of-two shift
    localparam int CY_W       = 36;
    localparam int CQ_W       = 32;
    localparam int PL_W       = 54;
    localparam int PF_W       = 72;
    localparam int RCP_SH     = 40;
    localparam int RCP_LO_W   = 18;
    localparam int DIV_K      = 25;
    localparam int PRED_SH    = 10;
    localparam int DELTA_SH   = 26;
    localparam longint RECIP    = (64'sd1 <<< RCP_SH) / DIV_K;
    localparam longint RECIP_HI = RECIP >>> RCP_LO_W;
    localparam longint RECIP_LO = RECIP - (RECIP_HI <<< RCP_LO_W);

    localparam int  W_MAX      = (1 << (W_W - 1)) - 1;
    localparam int  W_MAXP1    = 1 << (W_W - 1);
    localparam int  W_RESET    = 1 << (FRAC_BITS - 2);
    localparam int  LR_RESET   = 655;
    localparam longint METRIC_DIV = 25600;
    localparam longint DELTA_DIV  = METRIC_DIV << LR_FRAC;

    typedef enum logic [3:0] {
        LOP_NONE,
        LOP_CAPTURE,
        LOP_PROD,
        LOP_ERRM,
        LOP_LRM,
        LOP_DELTA,
        LOP_SQUARE,
        LOP_NORM,
        LOP_LOAD
    } lane_op_t;

    typedef struct packed {
        lane_op_t                 op;
        logic signed [ERR_W-1:0]  err;
        logic [LR_W-1:0]          lr;
    } lane_ctrl_t;

    typedef struct packed {
        logic start_pred;
        logic start_sqrt;
    } merge_ctrl_t;

    typedef struct packed {
        logic                   pred_done;
        logic signed [W_W-1:0]  pred;
        logic                   norm_done;
        logic [ROOT_W-1:0]      norm;
    } merge_stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PROD,
        S_PSUM,
        S_PDIV,
        S_ERRM,
        S_LRM,
        S_DELTA,
        S_DWAIT,
        S_SQ,
        S_SSUM,
        S_SQRT,
        S_NORM,
        S_NWAIT,
        S_LOAD,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        CD_IDLE,
        CD_LOW,
        CD_HIGH,
        CD_FIX
    } cdiv_phase_t;

    typedef enum logic [1:0] {
        MODE_PREDICT = 2'd0,
        MODE_TRAIN   = 2'd1,
        MODE_LOAD    = 2'd2,
        MODE_SPARE   = 2'd3
    } mode_t;

    // signed result from magnitude and sign, clamped to the weight range
    function automatic logic signed [W_W-1:0] sat_mag(input logic [NUM_W-1:0] mag,
                                                      input logic neg);
        logic [W_W-1:0] lo;
        lo = mag[W_W-1:0];
        if (!neg)
            return (mag > NUM_W'(W_MAX)) ? W_W'(W_MAX) : $signed(lo);
        else
            return (mag > NUM_W'(W_MAXP1)) ? W_W'(W_MAXP1) : $signed(-lo);
    endfunction

    function automatic logic signed [W_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(W_MAX);
        lo = -SUM_W'(W_MAXP1);
        if (v > hi)
            return W_W'(W_MAX);
        else if (v < lo)
            return W_W'(W_MAXP1);
        else
            return v[W_W-1:0];
    endfunction

endpackage

// File: design/lmsp_if.sv
// ----------------------------------------------------------------------------
// lmsp_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface lmsp_in_if;
    logic                valid;
    logic                ready;
    logic [1:0]          mode;
    logic [14:0]         cpu_load;
    logic [14:0]         memory_load;
    logic signed [16:0]  temperature;
    logic [14:0]         battery;
    logic signed [17:0]  target_score;
    logic signed [23:0]  new_weight_0;
    logic signed [23:0]  new_weight_1;
    logic signed [23:0]  new_weight_2;
    logic signed [23:0]  new_weight_3;

    modport source (output valid, mode, cpu_load, memory_load, temperature, battery,
                    target_score, new_weight_0, new_weight_1, new_weight_2,
                    new_weight_3, input ready);
    modport sink (input valid, mode, cpu_load, memory_load, temperature, battery,
                  target_score, new_weight_0, new_weight_1, new_weight_2,
                  new_weight_3, output ready);
endinterface

interface lmsp_out_if;
    logic                valid;
    logic                ready;
    logic signed [23:0]  prediction;
    logic signed [23:0]  weight_out_0;
    logic signed [23:0]  weight_out_1;
    logic signed [23:0]  weight_out_2;
    logic signed [23:0]  weight_out_3;

    modport source (output valid, prediction, weight_out_0, weight_out_1,
                    weight_out_2, weight_out_3, input ready);
    modport sink (input valid, prediction, weight_out_0, weight_out_1,
                  weight_out_2, weight_out_3, output ready);
endinterface

// File: design/lmsp_div.sv
// ----------------------------------------------------------------------------
// lmsp_div
// Restoring unsigned divider, one quotient bit per cycle, and a divide-by-25
// unit built on a split reciprocal multiply with one correction step.
// ----------------------------------------------------------------------------
module lmsp_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lmsp_pkg::NUM_W-1:0]  num,
    input  logic [lmsp_pkg::DEN_W-1:0]  den,
    output logic                        done,
    output logic [lmsp_pkg::NUM_W-1:0]  quot
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [lmsp_pkg::DCNT_W-1:0] cnt_reg, cnt_next;
    logic [lmsp_pkg::NUM_W-1:0]  q_reg, q_next;
    logic [lmsp_pkg::DEN_W-1:0]  rem_reg, rem_next;
    logic [lmsp_pkg::DEN_W-1:0]  den_reg, den_next;
    logic [lmsp_pkg::DEN_W:0]    shifted;
    logic                        ge;

    assign shifted = {rem_reg, q_reg[lmsp_pkg::NUM_W-1]};
    assign ge      = shifted >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? lmsp_pkg::DEN_W'(shifted - {1'b0, den_reg})
                          : shifted[lmsp_pkg::DEN_W-1:0];
            q_next   = {q_reg[lmsp_pkg::NUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == lmsp_pkg::DCNT_W'(lmsp_pkg::NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

module lmsp_cdiv (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lmsp_pkg::CY_W-1:0]   num,
    output logic                        done,
    output logic [lmsp_pkg::CQ_W-1:0]   quot
);

    lmsp_pkg::cdiv_phase_t       phase_reg, phase_next;
    logic                        done_reg, done_next;
    logic [lmsp_pkg::CY_W-1:0]   y_reg, y_next;
    logic [lmsp_pkg::PL_W-1:0]   plo_reg, plo_next;
    logic [lmsp_pkg::CQ_W-1:0]   q0_reg, q0_next;
    logic [lmsp_pkg::CQ_W-1:0]   q_reg, q_next;
    logic [lmsp_pkg::PL_W-1:0]   phi;
    logic [lmsp_pkg::PF_W-1:0]   pfull;
    logic [lmsp_pkg::CY_W-1:0]   rem;

    assign phi   = lmsp_pkg::PL_W'(y_reg) * lmsp_pkg::PL_W'(lmsp_pkg::RECIP_HI);
    assign pfull = lmsp_pkg::PF_W'(plo_reg)
                 + (lmsp_pkg::PF_W'(phi) << lmsp_pkg::RCP_LO_W);
    // the estimate is low by at most one
    assign rem   = y_reg - lmsp_pkg::CY_W'(q0_reg) * lmsp_pkg::CY_W'(lmsp_pkg::DIV_K);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (start)
            phase_next = lmsp_pkg::CD_LOW;
        else
        begin
            case (phase_reg)
                lmsp_pkg::CD_LOW:  phase_next = lmsp_pkg::CD_HIGH;
                lmsp_pkg::CD_HIGH: phase_next = lmsp_pkg::CD_FIX;
                lmsp_pkg::CD_FIX:  phase_next = lmsp_pkg::CD_IDLE;
                default:           phase_next = lmsp_pkg::CD_IDLE;
            endcase
        end
    end

    // datapath per phase
    always_comb
    begin
        done_next = 1'b0;
        y_next    = y_reg;
        plo_next  = plo_reg;
        q0_next   = q0_reg;
        q_next    = q_reg;
        if (start)
            y_next = num;
        case (phase_reg)
            lmsp_pkg::CD_LOW:
            begin
                plo_next = lmsp_pkg::PL_W'(y_reg) * lmsp_pkg::PL_W'(lmsp_pkg::RECIP_LO);
            end
            lmsp_pkg::CD_HIGH:
            begin
                q0_next = pfull[lmsp_pkg::PF_W-1:lmsp_pkg::RCP_SH];
            end
            lmsp_pkg::CD_FIX:
            begin
                q_next    = q0_reg + lmsp_pkg::CQ_W'(rem >= lmsp_pkg::CY_W'(lmsp_pkg::DIV_K));
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= lmsp_pkg::CD_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg   <= y_next;
        plo_reg <= plo_next;
        q0_reg  <= q0_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// File: design/lmsp_sqrt.sv
// ----------------------------------------------------------------------------
// lmsp_sqrt
// Digit-by-digit square root, two radicand bits per cycle, rounded to nearest.
// ----------------------------------------------------------------------------
module lmsp_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lmsp_pkg::SSUM_W-1:0]  rad,
    output logic                         done,
    output logic [lmsp_pkg::ROOT_W-1:0]  root
);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [lmsp_pkg::SSUM_W-1:0]  x_reg, x_next;
    logic [lmsp_pkg::SSUM_W:0]    r_reg, r_next;
    logic [lmsp_pkg::SSUM_W-1:0]  bit_reg, bit_next;
    logic [lmsp_pkg::ROOT_W-1:0]  root_reg, root_next;
    logic [lmsp_pkg::SSUM_W:0]    trial;

    assign trial = r_reg + {1'b0, bit_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        x_next    = x_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            x_next    = rad;
            r_next    = '0;
            bit_next  = lmsp_pkg::SSUM_W'(1) << (lmsp_pkg::SSUM_W - 2);
        end
        else if (busy_reg)
        begin
            if (bit_reg == '0)
            begin
                // round up when the remainder exceeds the root
                busy_next = 1'b0;
                done_next = 1'b1;
                root_next = lmsp_pkg::ROOT_W'(r_reg)
                          + lmsp_pkg::ROOT_W'({1'b0, x_reg} > r_reg);
            end
            else
            begin
                if ({1'b0, x_reg} >= trial)
                begin
                    x_next = lmsp_pkg::SSUM_W'({1'b0, x_reg} - trial);
                    r_next = (r_reg >> 1) + {1'b0, bit_reg};
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        r_reg    <= r_next;
        bit_reg  <= bit_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: design/lmsp_lane.sv
// ----------------------------------------------------------------------------
// lmsp_lane
// One weight lane: holds its weight, forms products, runs a divide-by-25
// unit for the training step and its own divider for the normalization.
// ----------------------------------------------------------------------------
module lmsp_lane (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lmsp_pkg::lane_ctrl_t               ctrl,
    input  logic signed [lmsp_pkg::M_W-1:0]    metric,
    input  logic signed [lmsp_pkg::W_W-1:0]    new_w,
    input  logic [lmsp_pkg::ROOT_W-1:0]        norm,
    output logic signed [lmsp_pkg::W_W-1:0]    weight,
    output logic signed [lmsp_pkg::PROD_W-1:0] prod,
    output logic [lmsp_pkg::SQ_W-1:0]          square,
    output logic                               done
);

    logic signed [lmsp_pkg::W_W-1:0]    w_reg, w_next;
    logic signed [lmsp_pkg::M_W-1:0]    m_reg;
    logic signed [lmsp_pkg::W_W-1:0]    nw_reg;
    logic signed [lmsp_pkg::PROD_W-1:0] prod_reg;
    logic signed [lmsp_pkg::EM_W-1:0]   em_reg;
    logic signed [lmsp_pkg::FULL_W-1:0] full_reg;
    logic [lmsp_pkg::SQ_W-1:0]          sq_reg;
    logic                               neg_reg;
    logic                               done_reg;

    logic                               div_start;
    logic [lmsp_pkg::NUM_W-1:0]         div_num;
    logic [lmsp_pkg::DEN_W-1:0]         div_den;
    logic                               div_done;
    logic [lmsp_pkg::NUM_W-1:0]         div_quot;

    logic                               cd_start;
    logic [lmsp_pkg::NUM_W-1:0]         delta_num;
    logic [lmsp_pkg::CY_W-1:0]          cd_num;
    logic                               cd_done;
    logic [lmsp_pkg::CQ_W-1:0]          cd_quot;

    logic [lmsp_pkg::FULL_W-1:0]        full_abs;
    logic [lmsp_pkg::W_W-1:0]           w_abs;
    logic [lmsp_pkg::SUM_W-2:0]         d_mag;
    logic signed [lmsp_pkg::SUM_W-1:0]  d_val;
    logic signed [lmsp_pkg::SUM_W-1:0]  w_sum;
    logic signed [lmsp_pkg::FULL_W-1:0] lr_s;

    assign full_abs = full_reg[lmsp_pkg::FULL_W-1] ? $unsigned(-full_reg)
                                                   : $unsigned(full_reg);
    assign w_abs    = w_reg[lmsp_pkg::W_W-1] ? $unsigned(-w_reg) : $unsigned(w_reg);
    assign lr_s     = $signed(lmsp_pkg::FULL_W'(ctrl.lr));

    // rate * error * metric / (25600 * 2^16): round, drop 26 bits, divide by 25
    assign delta_num = lmsp_pkg::NUM_W'(full_abs) + lmsp_pkg::NUM_W'(lmsp_pkg::DELTA_DIV / 2);
    assign cd_start  = (ctrl.op == lmsp_pkg::LOP_DELTA);
    assign cd_num    = lmsp_pkg::CY_W'(delta_num >> lmsp_pkg::DELTA_SH);

    assign div_start = (ctrl.op == lmsp_pkg::LOP_NORM);
    assign div_num   = (lmsp_pkg::NUM_W'(w_abs) << lmsp_pkg::FRAC_BITS)
                     + lmsp_pkg::NUM_W'(norm >> 1);
    assign div_den   = lmsp_pkg::DEN_W'(norm);

    lmsp_cdiv u_cdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cd_start),
        .num   (cd_num),
        .done  (cd_done),
        .quot  (cd_quot)
    );

    lmsp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // delta is small, the low bits of the quotient carry it
    assign d_mag = cd_quot[lmsp_pkg::SUM_W-2:0];
    assign d_val = neg_reg ? -$signed({1'b0, d_mag}) : $signed({1'b0, d_mag});
    assign w_sum = lmsp_pkg::SUM_W'(w_reg) + d_val;

    always_comb
    begin
        w_next = w_reg;
        if (cd_done)
            w_next = lmsp_pkg::sat_sum(w_sum);
        else if (div_done)
            w_next = lmsp_pkg::sat_mag(div_quot, neg_reg);
        else if (ctrl.op == lmsp_pkg::LOP_LOAD)
            w_next = nw_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg    <= lmsp_pkg::W_W'(lmsp_pkg::W_RESET);
            done_reg <= 1'b0;
        end
        else
        begin
            w_reg    <= w_next;
            done_reg <= cd_done || div_done;
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            lmsp_pkg::LOP_CAPTURE:
            begin
                m_reg  <= metric;
                nw_reg <= new_w;
            end
            lmsp_pkg::LOP_PROD:
            begin
                prod_reg <= lmsp_pkg::PROD_W'(w_reg) * lmsp_pkg::PROD_W'(m_reg);
            end
            lmsp_pkg::LOP_ERRM:
            begin
                em_reg <= lmsp_pkg::EM_W'(ctrl.err) * lmsp_pkg::EM_W'(m_reg);
            end
            lmsp_pkg::LOP_LRM:
            begin
                full_reg <= lmsp_pkg::FULL_W'(em_reg) * lr_s;
            end
            lmsp_pkg::LOP_DELTA:
            begin
                neg_reg <= full_reg[lmsp_pkg::FULL_W-1];
            end
            lmsp_pkg::LOP_SQUARE:
            begin
                sq_reg <= $unsigned(lmsp_pkg::SQ_W'(w_reg) * lmsp_pkg::SQ_W'(w_reg));
            end
            lmsp_pkg::LOP_NORM:
            begin
                neg_reg <= w_reg[lmsp_pkg::W_W-1];
            end
            default:
            begin
                m_reg <= m_reg;
            end
        endcase
    end

    assign weight = w_reg;
    assign prod   = prod_reg;
    assign square = sq_reg;
    assign done   = done_reg;

endmodule

// File: design/lmsp_merge.sv
// ----------------------------------------------------------------------------
// lmsp_merge
// Combines the lanes: sums products into the prediction and squares into
// the norm, each through its own iterative unit.
// ----------------------------------------------------------------------------
module lmsp_merge (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lmsp_pkg::merge_ctrl_t              ctrl,
    input  logic signed [lmsp_pkg::PROD_W-1:0] prod [lmsp_pkg::LANES],
    input  logic [lmsp_pkg::SQ_W-1:0]          square [lmsp_pkg::LANES],
    output lmsp_pkg::merge_stat_t              stat
);

    logic signed [lmsp_pkg::ACC_W-1:0] acc_reg;
    logic [lmsp_pkg::SSUM_W-1:0]       ssum_reg;
    logic                              pend_pred_reg;
    logic                              pend_sq_reg;
    logic                              pred_done_reg;
    logic signed [lmsp_pkg::W_W-1:0]   pred_reg;
    logic                              neg_reg;

    logic signed [lmsp_pkg::ACC_W-1:0] acc_sum;
    logic [lmsp_pkg::SSUM_W-1:0]       sq_sum;
    logic [lmsp_pkg::ACC_W-1:0]        acc_abs;
    logic [lmsp_pkg::NUM_W-1:0]        pred_num;
    logic                              div_done;
    logic [lmsp_pkg::CQ_W-1:0]         div_quot;
    logic                              sq_done;
    logic [lmsp_pkg::ROOT_W-1:0]       sq_root;

    always_comb
    begin
        acc_sum = '0;
        sq_sum  = '0;
        for (int i = 0; i < lmsp_pkg::LANES; i++)
        begin
            acc_sum = acc_sum + lmsp_pkg::ACC_W'(prod[i]);
            sq_sum  = sq_sum + lmsp_pkg::SSUM_W'(square[i]);
        end
    end

    assign acc_abs  = acc_reg[lmsp_pkg::ACC_W-1] ? $unsigned(-acc_reg) : $unsigned(acc_reg);
    // round, then 25600 = 25 * 2^10
    assign pred_num = lmsp_pkg::NUM_W'(acc_abs) + lmsp_pkg::NUM_W'(lmsp_pkg::METRIC_DIV / 2);

    lmsp_cdiv u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pend_pred_reg),
        .num   (lmsp_pkg::CY_W'(pred_num >> lmsp_pkg::PRED_SH)),
        .done  (div_done),
        .quot  (div_quot)
    );

    lmsp_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pend_sq_reg),
        .rad   (ssum_reg),
        .done  (sq_done),
        .root  (sq_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_pred_reg <= 1'b0;
            pend_sq_reg   <= 1'b0;
            pred_done_reg <= 1'b0;
        end
        else
        begin
            pend_pred_reg <= ctrl.start_pred;
            pend_sq_reg   <= ctrl.start_sqrt;
            pred_done_reg <= div_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start_pred)
            acc_reg <= acc_sum;
        if (ctrl.start_sqrt)
            ssum_reg <= sq_sum;
        if (pend_pred_reg)
            neg_reg <= acc_reg[lmsp_pkg::ACC_W-1];
        if (div_done)
            pred_reg <= lmsp_pkg::sat_mag(lmsp_pkg::NUM_W'(div_quot), neg_reg);
    end

    assign stat.pred_done = pred_done_reg;
    assign stat.pred      = pred_reg;
    assign stat.norm_done = sq_done;
    assign stat.norm      = sq_root;

endmodule

// File: design/lms_predictor_normalized.sv
// ----------------------------------------------------------------------------
// lms_predictor_normalized
// Four-weight LMS predictor with renormalized weights and a load mode.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in_ch     in   valid / ready      mode, four metrics, score, four weights
//  out_ch    out  valid / ready      prediction, four weights
//  cfg       in   cfg_we             learning rate (cfg_wdata)
//
//  one item at a time; ready is high only between items
//  training spends most of its time in the 25-step square root and the
//  60-step normalizing divider; a zero weight vector skips the divider
//  a result waiting on out_ch does not block the next item from entering
//  rst_n is asynchronous; weights come up at 0.25, learning rate at 655
// ----------------------------------------------------------------------------
module lms_predictor_normalized (
    input  logic                          clk,
    input  logic                          rst_n,
    lmsp_in_if.sink                       in_ch,
    lmsp_out_if.source                    out_ch,
    input  logic                          cfg_we,
    input  logic [lmsp_pkg::LR_W-1:0]     cfg_wdata
);

    lmsp_pkg::state_t                  state_reg, state_next;
    lmsp_pkg::lane_ctrl_t              lane_ctrl;
    lmsp_pkg::merge_ctrl_t             merge_ctrl;
    lmsp_pkg::merge_stat_t             merge_stat;
    lmsp_pkg::lane_op_t                lane_op;

    logic [lmsp_pkg::LR_W-1:0]         lr_reg;
    logic [1:0]                        mode_reg;
    logic signed [17:0]                target_reg;
    logic signed [lmsp_pkg::ERR_W-1:0] err_reg;
    logic                              out_valid_reg, out_valid_next;
    logic signed [lmsp_pkg::W_W-1:0]   pred_out_reg;
    logic signed [lmsp_pkg::W_W-1:0]   w_out_reg [lmsp_pkg::LANES];

    logic                              accept;
    logic                              out_load;
    logic                              lanes_done;
    logic                              start_pred;
    logic                              start_sqrt;
    logic                              in_ready;

    logic signed [lmsp_pkg::M_W-1:0]    metric [lmsp_pkg::LANES];
    logic signed [lmsp_pkg::W_W-1:0]    new_w [lmsp_pkg::LANES];
    logic signed [lmsp_pkg::W_W-1:0]    weight [lmsp_pkg::LANES];
    logic signed [lmsp_pkg::PROD_W-1:0] prod [lmsp_pkg::LANES];
    logic [lmsp_pkg::SQ_W-1:0]          square [lmsp_pkg::LANES];
    logic [lmsp_pkg::LANES-1:0]         lane_done;

    assign metric[0] = $signed({2'b00, in_ch.cpu_load});
    assign metric[1] = $signed({2'b00, in_ch.memory_load});
    assign metric[2] = in_ch.temperature;
    assign metric[3] = $signed({2'b00, in_ch.battery});
    assign new_w[0]  = in_ch.new_weight_0;
    assign new_w[1]  = in_ch.new_weight_1;
    assign new_w[2]  = in_ch.new_weight_2;
    assign new_w[3]  = in_ch.new_weight_3;

    assign accept     = in_ch.valid && in_ready;
    assign lanes_done = &lane_done;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lmsp_pkg::S_IDLE:  if (accept) state_next = lmsp_pkg::S_PROD;
            lmsp_pkg::S_PROD:  state_next = lmsp_pkg::S_PSUM;
            lmsp_pkg::S_PSUM:  state_next = lmsp_pkg::S_PDIV;
            lmsp_pkg::S_PDIV:
            begin
                if (merge_stat.pred_done)
                begin
                    case (mode_reg)
                        lmsp_pkg::MODE_TRAIN: state_next = lmsp_pkg::S_ERRM;
                        lmsp_pkg::MODE_LOAD:  state_next = lmsp_pkg::S_LOAD;
                        default:              state_next = lmsp_pkg::S_FIN;
                    endcase
                end
            end
            lmsp_pkg::S_ERRM:  state_next = lmsp_pkg::S_LRM;
            lmsp_pkg::S_LRM:   state_next = lmsp_pkg::S_DELTA;
            lmsp_pkg::S_DELTA: state_next = lmsp_pkg::S_DWAIT;
            lmsp_pkg::S_DWAIT: if (lanes_done) state_next = lmsp_pkg::S_SQ;
            lmsp_pkg::S_SQ:    state_next = lmsp_pkg::S_SSUM;
            lmsp_pkg::S_SSUM:  state_next = lmsp_pkg::S_SQRT;
            lmsp_pkg::S_SQRT:
            begin
                // zero vector stays as it is
                if (merge_stat.norm_done)
                    state_next = (merge_stat.norm == '0) ? lmsp_pkg::S_FIN
                                                         : lmsp_pkg::S_NORM;
            end
            lmsp_pkg::S_NORM:  state_next = lmsp_pkg::S_NWAIT;
            lmsp_pkg::S_NWAIT: if (lanes_done) state_next = lmsp_pkg::S_FIN;
            lmsp_pkg::S_LOAD:  state_next = lmsp_pkg::S_FIN;
            lmsp_pkg::S_FIN:   if (out_load) state_next = lmsp_pkg::S_IDLE;
            default:           state_next = lmsp_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready   = 1'b0;
        lane_op    = lmsp_pkg::LOP_NONE;
        start_pred = 1'b0;
        start_sqrt = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            lmsp_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_ch.valid)
                    lane_op = lmsp_pkg::LOP_CAPTURE;
            end
            lmsp_pkg::S_PROD:  lane_op = lmsp_pkg::LOP_PROD;
            lmsp_pkg::S_PSUM:  start_pred = 1'b1;
            lmsp_pkg::S_ERRM:  lane_op = lmsp_pkg::LOP_ERRM;
            lmsp_pkg::S_LRM:   lane_op = lmsp_pkg::LOP_LRM;
            lmsp_pkg::S_DELTA: lane_op = lmsp_pkg::LOP_DELTA;
            lmsp_pkg::S_SQ:    lane_op = lmsp_pkg::LOP_SQUARE;
            lmsp_pkg::S_SSUM:  start_sqrt = 1'b1;
            lmsp_pkg::S_NORM:  lane_op = lmsp_pkg::LOP_NORM;
            lmsp_pkg::S_LOAD:  lane_op = lmsp_pkg::LOP_LOAD;
            lmsp_pkg::S_FIN:   out_load = !out_valid_reg || out_ch.ready;
            default:           lane_op = lmsp_pkg::LOP_NONE;
        endcase
    end

    assign lane_ctrl.op          = lane_op;
    assign lane_ctrl.err         = err_reg;
    assign lane_ctrl.lr          = lr_reg;
    assign merge_ctrl.start_pred = start_pred;
    assign merge_ctrl.start_sqrt = start_sqrt;

    for (genvar g = 0; g < lmsp_pkg::LANES; g++)
    begin : g_lane
        lmsp_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (lane_ctrl),
            .metric (metric[g]),
            .new_w  (new_w[g]),
            .norm   (merge_stat.norm),
            .weight (weight[g]),
            .prod   (prod[g]),
            .square (square[g]),
            .done   (lane_done[g])
        );
    end

    lmsp_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (merge_ctrl),
        .prod   (prod),
        .square (square),
        .stat   (merge_stat)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lmsp_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            lr_reg        <= lmsp_pkg::LR_W'(lmsp_pkg::LR_RESET);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                lr_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= in_ch.mode;
            target_reg <= in_ch.target_score;
        end
        if (merge_stat.pred_done)
            err_reg <= lmsp_pkg::ERR_W'(target_reg) - lmsp_pkg::ERR_W'(merge_stat.pred);
        if (out_load)
        begin
            pred_out_reg <= merge_stat.pred;
            for (int i = 0; i < lmsp_pkg::LANES; i++)
                w_out_reg[i] <= weight[i];
        end
    end

    assign in_ch.ready         = in_ready;
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.prediction   = pred_out_reg;
    assign out_ch.weight_out_0 = w_out_reg[0];
    assign out_ch.weight_out_1 = w_out_reg[1];
    assign out_ch.weight_out_2 = w_out_reg[2];
    assign out_ch.weight_out_3 = w_out_reg[3];

endmodule

// File: design/lmsp_checker.sv
// ----------------------------------------------------------------------------
// lmsp_checker
// Port-level checks on the predictor's item flow, bound to the top level.
// ----------------------------------------------------------------------------
`include "lms_predictor_normalized_defines.svh"

module lmsp_port_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_ready,
    input  logic         out_valid,
    input  logic         out_ready,
    input  logic [23:0]  out_pred
);

    // one item in flight: taking an item closes the input
    `LMSP_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    // a result only appears after work, never straight from idle
    `LMSP_ASSERT_IMP(a_result_after_work, $rose(out_valid), !$past(in_ready))

    `LMSP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pred))

endmodule

bind lms_predictor_normalized lmsp_port_checker u_lmsp_port_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_pred  (out_ch.prediction)
);
